// ----- src/fes_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fes_pkg;

  localparam int KIND_W    = 2;
  localparam int CLUSTER_W = 13;
  localparam int ENTRY_W   = 28;
  // byte offset of an entry: at most 4 * (2**CLUSTER_W - 1)
  localparam int OFF_W     = CLUSTER_W + 2;

  localparam logic [KIND_W-1:0] KIND_FAT12 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAT16 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FAT32 = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  localparam logic [15:0] FAT12_LOW_MASK  = 16'h0FFF;
  localparam logic [15:0] FAT12_HIGH_KEEP = 16'hF000;
  localparam logic [15:0] FAT12_LOW_KEEP  = 16'h000F;
  localparam logic [31:0] FAT32_MASK      = 32'h0FFF_FFFF;

endpackage

`default_nettype wire

// ----- src/fat_entry_store_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// FAT entry store. Holds a FAT region of TABLE_BYTES bytes and serves one
// read or write request per table entry; fat_kind (FAT12, FAT16, FAT32, code
// 3 behaving as FAT32) sets the entry layout. The bytes sit in four byte-lane
// banks with a synchronous read, so the up to four bytes of an entry (also
// a FAT12 pair that straddles a row) come out in one read. A request reads
// the lanes when it is accepted; in the modify-write state the new entry is
// merged and the lanes are written back through the same port. One result
// register sits on the output, so a new request is taken while the previous
// result still waits; only a result that is still held back when the
// modify-write is due stalls the modify-write state. After reset the block
// runs a clearing pass, one row of all four lanes per cycle, during which
// in_stall stays high (cfg writes are taken). A request whose entry reaches
// past the store returns status 1 with entry value 0 and leaves the store
// untouched. Write fat_kind only while no request is in flight.
module fat_entry_store_core
  import fes_pkg::*;
#(
  parameter int TABLE_BYTES = 8192
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_wr_en,
  input  wire logic [KIND_W-1:0]    cfg_wr_data,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_command,
  input  wire logic [CLUSTER_W-1:0] in_cluster_index,
  input  wire logic [ENTRY_W-1:0]   in_write_value,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ENTRY_W-1:0]        out_entry_value,
  output logic                      out_status
);

  localparam int BANK_DEPTH = (TABLE_BYTES + 3) / 4;
  localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BANK_DEPTH - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD
  } state_t;

  state_t               state_r;
  logic [KIND_W-1:0]    fat_kind_r;
  logic [ROW_W-1:0]     clr_cnt_r;

  // request held between the read and the modify-write cycle
  logic                 req_write_r;
  logic                 req_odd_r;
  logic                 req_oob_r;
  logic [1:0]           req_sh_r;
  logic [3:0]           req_used_r;
  logic [ENTRY_W-1:0]   req_value_r;
  logic [ROW_W-1:0]     req_row_r [4];

  logic                 out_valid_r;
  logic [ENTRY_W-1:0]   out_entry_r;
  logic                 out_status_r;

  // lane ports
  logic [ROW_W-1:0]     lane_addr  [4];
  logic [7:0]           lane_wdata [4];
  logic [3:0]           lane_we;
  logic                 lane_re;
  logic [7:0]           lane_q_r   [4];

  // request decode
  logic                 accept;
  logic [OFF_W-1:0]     off;
  logic                 len4;
  logic [OFF_W:0]       end_pos;
  logic                 oob;
  logic [CLUSTER_W-1:0] base_row;
  logic [ROW_W-1:0]     rd_row [4];
  logic [3:0]           used;
  logic [1:0]           lane_k;

  // modify stage
  logic [3:0][7:0]      ent_w;
  logic [3:0][7:0]      new_w;
  logic [31:0]          result;
  logic                 advance;

  assign in_stall        = (state_r != S_IDLE);
  assign accept          = in_valid && !in_stall;
  assign advance         = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_entry_value = out_entry_r;
  assign out_status      = out_status_r;

  // Locate the entry: offset, length, lanes touched and row of each lane.
  always_comb begin
    case (fat_kind_r)
      KIND_FAT12: begin
        off  = OFF_W'(in_cluster_index) + OFF_W'(in_cluster_index >> 1);
        len4 = 1'b0;
      end
      KIND_FAT16: begin
        off  = OFF_W'({in_cluster_index, 1'b0});
        len4 = 1'b0;
      end
      default: begin
        off  = {in_cluster_index, 2'b00};
        len4 = 1'b1;
      end
    endcase
    end_pos  = {1'b0, off} + (len4 ? (OFF_W + 1)'(4) : (OFF_W + 1)'(2));
    oob      = 32'(end_pos) > 32'(TABLE_BYTES);
    base_row = off[OFF_W-1:2];
    for (int b = 0; b < 4; b++) begin
      lane_k    = 2'(b) - off[1:0];
      used[b]   = len4 || !lane_k[1];
      // lanes below the start byte wrap into the next row
      rd_row[b] = ROW_W'({1'b0, base_row} + {{CLUSTER_W{1'b0}}, (2'(b) < off[1:0])});
    end
  end

  // Gather the entry, compute the result and the merged bytes.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ent_w[k] = lane_q_r[2'(k) + req_sh_r];
    end
    new_w  = ent_w;
    result = '0;
    case (fat_kind_r)
      KIND_FAT12: begin
        if (req_write_r == CMD_WRITE) begin
          result = {20'b0, req_value_r[11:0]};
          if (req_odd_r) begin
            new_w[1:0] = (ent_w[1:0] & FAT12_LOW_KEEP) | {req_value_r[11:0], 4'b0};
          end else begin
            new_w[1:0] = (ent_w[1:0] & FAT12_HIGH_KEEP) | {4'b0, req_value_r[11:0]};
          end
        end else if (req_odd_r) begin
          result = {20'b0, ent_w[1][7:0], ent_w[0][7:4]};
        end else begin
          result = {16'b0, ent_w[1:0] & FAT12_LOW_MASK};
        end
      end
      KIND_FAT16: begin
        if (req_write_r == CMD_WRITE) begin
          result     = {16'b0, req_value_r[15:0]};
          new_w[1:0] = req_value_r[15:0];
        end else begin
          result = {16'b0, ent_w[1:0]};
        end
      end
      default: begin
        // FAT32; the spare code lays out entries the same way
        if (req_write_r == CMD_WRITE) begin
          result = {4'b0, req_value_r};
          new_w  = {4'b0, req_value_r};
        end else begin
          result = ent_w & FAT32_MASK;
        end
      end
    endcase
  end

  // Lane port control: clear sweep, read at accept, write back on advance.
  always_comb begin
    lane_re = accept && !oob;
    for (int b = 0; b < 4; b++) begin
      lane_addr[b]  = rd_row[b];
      lane_wdata[b] = new_w[2'(b) - req_sh_r];
      lane_we[b]    = 1'b0;
      if (state_r == S_CLEAR) begin
        lane_addr[b]  = clr_cnt_r;
        lane_wdata[b] = '0;
        lane_we[b]    = 1'b1;
      end else if (state_r == S_MOD) begin
        lane_addr[b] = req_row_r[b];
        lane_we[b]   = advance && (req_write_r == CMD_WRITE) && !req_oob_r &&
                       req_used_r[b];
      end
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_lane
    logic [7:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (lane_we[b]) begin
        mem[lane_addr[b]] <= lane_wdata[b];
      end
      if (lane_re) begin
        lane_q_r[b] <= mem[lane_addr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fat_kind_r  <= KIND_FAT16;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fat_kind_r <= cfg_wr_data;
      end
      // drop the result once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + ROW_W'(1);
          if (clr_cnt_r == LAST_ROW) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          // hold the request until the result register frees up
          if (advance) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request capture and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_write_r <= in_command;
      req_odd_r   <= in_cluster_index[0];
      req_oob_r   <= oob;
      req_sh_r    <= off[1:0];
      req_used_r  <= used;
      req_value_r <= in_write_value;
      for (int b = 0; b < 4; b++) begin
        req_row_r[b] <= rd_row[b];
      end
    end
    if (state_r == S_MOD && advance) begin
      out_entry_r  <= req_oob_r ? '0 : result[ENTRY_W-1:0];
      out_status_r <= req_oob_r ? STATUS_OUTSIDE : STATUS_OK;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("request accepted during clearing pass");

  a_accept_to_mod : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MOD))
    else $error("accepted request did not reach modify cycle");

  a_mod_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && advance) |=> (out_valid_r && state_r == S_IDLE))
    else $error("modify cycle did not load the result");

  a_oob_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD && req_oob_r) |-> (lane_we == 4'b0000))
    else $error("store written for entry outside the store");

  a_outside_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_OUTSIDE) |-> (out_entry_r == '0))
    else $error("outside status with nonzero entry value");
`endif

endmodule

`default_nettype wire
